/* sv/pru_pkg.sv */
package pru_pkg;

  localparam int MAX_ROW_BYTES = 8192;
  localparam int ROW_AW = $clog2(MAX_ROW_BYTES);
  localparam int LEN_W = ROW_AW + 1;

  localparam int BPP_W = 3;
  localparam int LEN_CFG_W = 14;
  localparam int CFG_W = 14;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [7:0] FILT_NONE  = 8'd0;
  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  typedef enum logic {
    CFG_BPP = 1'b0,
    CFG_LEN = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_ERROR = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t        kind;
    logic [7:0]        data;
    logic [2:0]        filt;
    logic [ROW_AW-1:0] col;
    logic              first_row;
    logic              has_left;
    logic              last;
  } q_item_t;

  function automatic logic [BPP_W-1:0] eff_bpp(input logic [BPP_W-1:0] r);
    if (r == '0) return BPP_W'(1);
    if (r > BPP_W'(4)) return BPP_W'(4);
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_CFG_W-1:0] r);
    if (r == '0) return LEN_W'(1);
    if (32'(r) > 32'(MAX_ROW_BYTES)) return LEN_W'(MAX_ROW_BYTES);
    return LEN_W'(r);
  endfunction

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] p;
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [10:0] pa;
    logic [10:0] pb;
    logic [10:0] pc;
    p  = $signed({3'b0, a}) + $signed({3'b0, b}) - $signed({3'b0, c});
    da = p - $signed({3'b0, a});
    db = p - $signed({3'b0, b});
    dc = p - $signed({3'b0, c});
    pa = (da < 0) ? 11'(-da) : 11'(da);
    pb = (db < 0) ? 11'(-db) : 11'(db);
    pc = (dc < 0) ? 11'(-dc) : 11'(dc);
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

endpackage

/* sv/pru_ram.sv */
module pru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/pru_front.sv */
module pru_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic [7:0]                    in_byte,
  input  logic                          image_start,
  input  logic [pru_pkg::BPP_W-1:0]     cfg_bpp,
  input  logic [pru_pkg::LEN_CFG_W-1:0] cfg_len,
  output logic                          push,
  output pru_pkg::q_item_t              push_item
);

  logic [pru_pkg::ROW_AW-1:0] col_r, col_nxt;
  logic [2:0]                 filt_r, filt_nxt;
  logic                       first_r, first_nxt;
  logic                       await_r, await_nxt;
  logic                       failed_r, failed_nxt;

  logic [pru_pkg::ROW_AW-1:0] f_col;
  logic [pru_pkg::ROW_AW-1:0] c;
  logic [2:0]                 f_filt;
  logic                       f_first;
  logic                       f_await;
  logic                       f_failed;
  logic [pru_pkg::LEN_W-1:0]  len;
  logic [pru_pkg::BPP_W-1:0]  bpp;
  logic [pru_pkg::LEN_W-1:0]  c_inc;
  logic                       last;

  assign len = pru_pkg::eff_len(cfg_len);
  assign bpp = pru_pkg::eff_bpp(cfg_bpp);

  always_comb begin
    f_col    = image_start ? '0 : col_r;
    f_filt   = image_start ? 3'd0 : filt_r;
    f_first  = image_start ? 1'b1 : first_r;
    f_await  = image_start ? 1'b1 : await_r;
    f_failed = image_start ? 1'b0 : failed_r;
    c        = (pru_pkg::LEN_W'(f_col) >= len) ? pru_pkg::ROW_AW'(len - 1'b1) : f_col;
    c_inc    = pru_pkg::LEN_W'(c) + 1'b1;
    last     = (c_inc >= len);
  end

  always_comb begin
    col_nxt    = col_r;
    filt_nxt   = filt_r;
    first_nxt  = first_r;
    await_nxt  = await_r;
    failed_nxt = failed_r;
    push       = 1'b0;
    push_item  = '{kind: pru_pkg::KIND_ERROR, data: '0, filt: '0, col: '0,
                   first_row: 1'b0, has_left: 1'b0, last: 1'b0};
    if (in_fire) begin
      col_nxt    = f_col;
      filt_nxt   = f_filt;
      first_nxt  = f_first;
      await_nxt  = f_await;
      failed_nxt = f_failed;
      priority if (f_failed) begin
        push = 1'b1;
      end else if (f_await) begin
        if (in_byte > pru_pkg::FILT_PAETH) begin
          failed_nxt = 1'b1;
          push       = 1'b1;
        end else begin
          filt_nxt  = in_byte[2:0];
          await_nxt = 1'b0;
          col_nxt   = '0;
        end
      end else begin
        push                = 1'b1;
        push_item.kind      = pru_pkg::KIND_DATA;
        push_item.data      = in_byte;
        push_item.filt      = f_filt;
        push_item.col       = c;
        push_item.first_row = f_first;
        push_item.has_left  = (32'(c) >= 32'(bpp));
        push_item.last      = last;
        if (last) begin
          col_nxt   = '0;
          await_nxt = 1'b1;
          first_nxt = 1'b0;
        end else begin
          col_nxt = c_inc[pru_pkg::ROW_AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      filt_r   <= '0;
      first_r  <= 1'b1;
      await_r  <= 1'b1;
      failed_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      filt_r   <= filt_nxt;
      first_r  <= first_nxt;
      await_r  <= await_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

/* sv/pru_queue.sv */
module pru_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pru_pkg::q_item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output pru_pkg::q_item_t head
);

  pru_pkg::q_item_t         slots_r [pru_pkg::QDEPTH];
  logic [pru_pkg::QAW-1:0]  wptr_r, wptr_nxt;
  logic [pru_pkg::QAW-1:0]  rptr_r, rptr_nxt;
  logic [pru_pkg::QAW:0]    count_r, count_nxt;

  assign full      = (count_r == (pru_pkg::QAW+1)'(pru_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slots_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r + (pru_pkg::QAW+1)'(push) - (pru_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* sv/pru_back.sv */
module pru_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  pru_pkg::q_item_t          q_head,
  output logic                      q_pop,
  input  logic [pru_pkg::BPP_W-1:0] cfg_bpp,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte,
  output logic                      out_row_end,
  output logic                      out_error
);

  pru_pkg::q_item_t s1_r;
  logic             s1_valid_r;
  logic             fwd_hit_r;
  logic [7:0]       fwd_data_r;
  logic [31:0]      lh_r, lh_nxt;
  logic [31:0]      ul_r, ul_nxt;
  logic             ov_r;
  logic [7:0]       ob_r;
  logic             ol_r;
  logic             oe_r;

  logic             s1_adv;
  logic             s1_fire;
  logic             ram_we;
  logic [7:0]       ram_rd;
  logic [pru_pkg::BPP_W-1:0] bpp;
  logic [1:0]       sel;
  logic [7:0]       left, up, upleft, lh_b, ul_b, pred, value;
  logic [8:0]       avg_sum;

  assign bpp     = pru_pkg::eff_bpp(cfg_bpp);
  assign sel     = 2'(bpp - 1'b1);
  assign s1_adv  = !ov_r || out_ready;
  assign s1_fire = s1_valid_r && s1_adv;
  assign q_pop   = q_valid && (!s1_valid_r || s1_adv);
  assign ram_we  = s1_fire && (s1_r.kind == pru_pkg::KIND_DATA);

  always_comb begin
    unique case (sel)
      2'd0: begin lh_b = lh_r[7:0];   ul_b = ul_r[7:0];   end
      2'd1: begin lh_b = lh_r[15:8];  ul_b = ul_r[15:8];  end
      2'd2: begin lh_b = lh_r[23:16]; ul_b = ul_r[23:16]; end
      default: begin lh_b = lh_r[31:24]; ul_b = ul_r[31:24]; end
    endcase
    left    = s1_r.has_left ? lh_b : 8'd0;
    up      = s1_r.first_row ? 8'd0 : (fwd_hit_r ? fwd_data_r : ram_rd);
    upleft  = (!s1_r.first_row && s1_r.has_left) ? ul_b : 8'd0;
    avg_sum = {1'b0, left} + {1'b0, up};
    unique case (8'(s1_r.filt))
      pru_pkg::FILT_SUB:   pred = left;
      pru_pkg::FILT_UP:    pred = up;
      pru_pkg::FILT_AVG:   pred = avg_sum[8:1];
      pru_pkg::FILT_PAETH: pred = pru_pkg::paeth(left, up, upleft);
      default:             pred = 8'd0;
    endcase
    value  = s1_r.data + pred;
    lh_nxt = ram_we ? {lh_r[23:0], value} : lh_r;
    ul_nxt = ram_we ? {ul_r[23:0], up} : ul_r;
  end

  pru_ram #(
    .WIDTH(8),
    .DEPTH(pru_pkg::MAX_ROW_BYTES)
  ) u_prev_row (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_r.col),
    .wdata(value),
    .re   (q_pop),
    .raddr(q_head.col),
    .rdata(ram_rd)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r       <= q_head;
      fwd_hit_r  <= ram_we && (s1_r.col == q_head.col);
      fwd_data_r <= value;
    end
    if (s1_fire) begin
      ob_r <= (s1_r.kind == pru_pkg::KIND_ERROR) ? 8'd0 : value;
      ol_r <= (s1_r.kind == pru_pkg::KIND_DATA) && s1_r.last;
      oe_r <= (s1_r.kind == pru_pkg::KIND_ERROR);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      ov_r       <= 1'b0;
      lh_r       <= '0;
      ul_r       <= '0;
    end else begin
      lh_r <= lh_nxt;
      ul_r <= ul_nxt;
      if (q_pop) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid   = ov_r;
  assign out_byte    = ob_r;
  assign out_row_end = ol_r;
  assign out_error   = oe_r;

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oe_r |-> (ob_r == 8'd0) && !ol_r)
    else $error("error result carries data");

  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (fwd_hit_r == $past(ram_we && (s1_r.col == q_head.col))))
    else $error("forward flag does not match write");

  a_no_pop_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |-> !q_pop)
    else $error("pop while stage held");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> ov_r)
    else $error("result lost at output register");

endmodule

/* sv/png_row_unfilter.sv */
// PNG row unfilter for 8-bit, non-interlaced images.
// in_*: filtered stream, one byte per request; in_tuser marks the first byte
// of a new image, which is the filter type of its first row. Each row starts
// with a filter byte (none, sub, up, average, Paeth); a valid one gives no result.
// out_*: one reconstructed byte per data byte; out_tlast marks the last byte
// of a row, out_tuser flags an error result (bad filter type in this image,
// byte forced to zero) until the next image start.
// cfg_*: index 0 bytes_per_pixel, index 1 row_length; write only while idle.
// Throughput: one byte per cycle while out_tready stays high. A data byte's
// result passes through a four-entry queue, a stage that reads the
// previous-row RAM, and the output register, with the left byte fed back
// from that stage to itself on each data byte.
// Reset clears the queue, the output valid flag and the row state; the
// previous-row RAM is not cleared, and only bytes written on the prior row are used.
// When out_tready is low the output register holds, the back stage and queue
// fill, and in_tready drops once the queue is full.
module png_row_unfilter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] in_byte
  input  logic                          in_tuser,   // [0] image_start
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] out_byte
  output logic                          out_tlast,
  output logic                          out_tuser,  // [0] error
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [pru_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [pru_pkg::BPP_W-1:0]     bpp_r;
  logic [pru_pkg::LEN_CFG_W-1:0] len_r;
  logic                          q_full;
  logic                          q_valid;
  logic                          q_pop;
  logic                          push;
  pru_pkg::q_item_t              push_item;
  pru_pkg::q_item_t              q_head;
  logic                          in_fire;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r <= pru_pkg::BPP_W'(1);
      len_r <= pru_pkg::LEN_CFG_W'(1);
    end else if (cfg_we) begin
      unique case (pru_pkg::cfg_idx_t'(cfg_index))
        pru_pkg::CFG_BPP: bpp_r <= cfg_wdata[pru_pkg::BPP_W-1:0];
        pru_pkg::CFG_LEN: len_r <= cfg_wdata[pru_pkg::LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  pru_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_byte    (in_tdata),
    .image_start(in_tuser),
    .cfg_bpp    (bpp_r),
    .cfg_len    (len_r),
    .push       (push),
    .push_item  (push_item)
  );

  pru_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .head     (q_head)
  );

  pru_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .cfg_bpp    (bpp_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_row_end(out_tlast),
    .out_error  (out_tuser)
  );

endmodule
